FILE: sv/bst_pkg.sv
`timescale 1ns / 1ps

package bst_pkg;

  // Table geometry
  localparam int NUM_SLOTS   = 64;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int SLOT_PORT_W = 6;
  localparam int FILE_W      = 16;
  localparam int OFF_W       = 24;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int REF_W       = 8;
  localparam logic [REF_W-1:0] REF_MAX = '1;

  // Stream widths, padded to whole bytes
  localparam int IN_BITS  = OP_W + FILE_W + OFF_W + SLOT_PORT_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = SLOT_PORT_W + STATUS_W + 3 + FILE_W + OFF_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [SLOT_W-1:0] idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_GET,
    OP_MARK_LOADED,
    OP_PIN,
    OP_UNPIN,
    OP_DIRTY,
    OP_UNDIRTY,
    OP_RELEASE,
    OP_FLUSH
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_NO_FREE,
    STAT_FLUSH_REF,
    STAT_IGNORED
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT_RD,
    S_SLOT_EXEC,
    S_DONE
  } state_t;

  // One slot record as held in the table memory
  typedef struct packed {
    logic              valid;
    logic [FILE_W-1:0] file;
    logic [OFF_W-1:0]  offset;
    logic [REF_W-1:0]  refs;
    logic              pinned;
    logic              dirty;
    logic              loaded;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic slot_rd;
    logic slot_exec;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_op;
    logic done;
  } stat_t;

endpackage

FILE: sv/bst_ctrl.sv
`timescale 1ns / 1ps

module bst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  bst_pkg::stat_t       stat,
  output bst_pkg::cmd_t        cmd
);

  bst_pkg::state_t state;
  bst_pkg::state_t state_next;

  // State register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bst_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Sequence one operation at a time
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      bst_pkg::S_IDLE: begin
        // Hold off input beats while reset is applied
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.load   = 1'b1;
          state_next = stat.scan_op ? bst_pkg::S_SCAN : bst_pkg::S_SLOT_RD;
        end
      end
      bst_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.done) begin
          state_next = bst_pkg::S_DONE;
        end
      end
      bst_pkg::S_SLOT_RD: begin
        cmd.slot_rd = 1'b1;
        state_next  = bst_pkg::S_SLOT_EXEC;
      end
      bst_pkg::S_SLOT_EXEC: begin
        cmd.slot_exec = 1'b1;
        state_next    = bst_pkg::S_DONE;
      end
      bst_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = bst_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/bst_dpath.sv
`timescale 1ns / 1ps

module bst_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  bst_pkg::cmd_t              cmd,
  output bst_pkg::stat_t             stat,
  input  logic [bst_pkg::IN_W-1:0]   s_tdata,
  output logic [bst_pkg::OUT_W-1:0]  m_tdata
);

  // Unpacked input beat
  bst_pkg::op_t                        in_op;
  logic [bst_pkg::FILE_W-1:0]          in_fid;
  logic [bst_pkg::OFF_W-1:0]           in_off;
  logic [bst_pkg::SLOT_PORT_W-1:0]     in_slot;

  // Captured operation
  bst_pkg::op_t                        op_r;
  logic [bst_pkg::FILE_W-1:0]          fid_r;
  logic [bst_pkg::OFF_W-1:0]           off_r;
  logic [bst_pkg::SLOT_PORT_W-1:0]     slot_r;

  // Scan pipeline
  logic [bst_pkg::CNT_W-1:0]           rd_addr;
  logic                                eval_vld;
  bst_pkg::idx_t                       eval_idx;
  logic                                have_free;
  bst_pkg::idx_t                       free_slot;

  // Table memory and per-slot written bits
  bst_pkg::entry_t                     mem [bst_pkg::NUM_SLOTS];
  logic [bst_pkg::NUM_SLOTS-1:0]       init_bits;
  bst_pkg::entry_t                     rd_data;
  logic                                rd_init;
  bst_pkg::idx_t                       rd_sel;
  bst_pkg::entry_t                     seen;

  // Write port
  logic                                wr_en;
  bst_pkg::idx_t                       wr_addr;
  bst_pkg::entry_t                     wr_data;

  // Result register
  logic [bst_pkg::SLOT_PORT_W-1:0]     res_slot,   res_slot_next;
  bst_pkg::status_t                    res_status, res_status_next;
  logic                                res_hit,    res_hit_next;
  logic                                res_nload,  res_nload_next;
  logic                                res_wb,     res_wb_next;
  logic [bst_pkg::FILE_W-1:0]          res_wbf,    res_wbf_next;
  logic [bst_pkg::OFF_W-1:0]           res_wbo,    res_wbo_next;

  logic                                done;
  logic                                scan_eval;
  logic                                cnt_zero;
  logic                                tag_hit;
  logic                                last_slot;
  logic                                slot_oor;
  bst_pkg::idx_t                       fin_slot;
  bst_pkg::idx_t                       slot_idx;

  assign in_op   = bst_pkg::op_t'(s_tdata[bst_pkg::OP_W-1:0]);
  assign in_fid  = s_tdata[bst_pkg::OP_W +: bst_pkg::FILE_W];
  assign in_off  = s_tdata[bst_pkg::OP_W + bst_pkg::FILE_W +: bst_pkg::OFF_W];
  assign in_slot = s_tdata[bst_pkg::OP_W + bst_pkg::FILE_W + bst_pkg::OFF_W +:
                           bst_pkg::SLOT_PORT_W];

  assign stat.scan_op = (in_op == bst_pkg::OP_GET) || (in_op == bst_pkg::OP_FLUSH);
  assign stat.done    = done;

  // Read address: scan counter or the addressed slot
  assign slot_idx = bst_pkg::idx_t'(slot_r);
  assign rd_sel   = cmd.slot_rd ? slot_idx : rd_addr[bst_pkg::SLOT_W-1:0];
  assign seen     = rd_init ? rd_data : '0;
  assign slot_oor = bst_pkg::CNT_W'(slot_r) >= bst_pkg::CNT_W'(bst_pkg::NUM_SLOTS);

  assign scan_eval = cmd.scan && eval_vld;
  assign cnt_zero  = (seen.refs == '0);
  assign tag_hit   = seen.valid && (seen.file == fid_r) &&
                     ((op_r == bst_pkg::OP_FLUSH) || (seen.offset == off_r));
  assign last_slot = (eval_idx == bst_pkg::idx_t'(bst_pkg::NUM_SLOTS - 1));
  assign fin_slot  = have_free ? free_slot : eval_idx;

  // Evaluate one slot per cycle, or apply a slot operation
  always_comb begin
    done            = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = eval_idx;
    wr_data         = seen;
    res_slot_next   = '0;
    res_status_next = bst_pkg::STAT_OK;
    res_hit_next    = 1'b0;
    res_nload_next  = 1'b0;
    res_wb_next     = 1'b0;
    res_wbf_next    = '0;
    res_wbo_next    = '0;
    if (scan_eval) begin
      if (op_r == bst_pkg::OP_GET) begin
        if (tag_hit) begin
          done          = 1'b1;
          wr_en         = 1'b1;
          if (seen.refs != bst_pkg::REF_MAX) begin
            wr_data.refs = seen.refs + bst_pkg::REF_W'(1);
          end
          res_slot_next  = bst_pkg::SLOT_PORT_W'(eval_idx);
          res_hit_next   = 1'b1;
          res_nload_next = !seen.loaded;
        end else if (last_slot) begin
          done = 1'b1;
          if (have_free || cnt_zero) begin
            wr_en          = 1'b1;
            wr_addr        = fin_slot;
            wr_data        = '0;
            wr_data.valid  = 1'b1;
            wr_data.file   = fid_r;
            wr_data.offset = off_r;
            wr_data.refs   = bst_pkg::REF_W'(1);
            res_slot_next  = bst_pkg::SLOT_PORT_W'(fin_slot);
            res_nload_next = 1'b1;
          end else begin
            res_status_next = bst_pkg::STAT_NO_FREE;
          end
        end
      end else begin
        if (tag_hit && !cnt_zero) begin
          done            = 1'b1;
          res_status_next = bst_pkg::STAT_FLUSH_REF;
          res_slot_next   = bst_pkg::SLOT_PORT_W'(eval_idx);
        end else begin
          if (tag_hit) begin
            wr_en   = 1'b1;
            wr_data = '0;
          end
          if (last_slot) begin
            done = 1'b1;
          end
        end
      end
    end else if (cmd.slot_exec) begin
      done          = 1'b1;
      wr_addr       = slot_idx;
      res_slot_next = slot_r;
      if (slot_oor) begin
        res_status_next = bst_pkg::STAT_IGNORED;
      end else begin
        case (op_r)
          bst_pkg::OP_MARK_LOADED: begin
            wr_en          = 1'b1;
            wr_data.loaded = 1'b1;
          end
          bst_pkg::OP_PIN: begin
            wr_en          = 1'b1;
            wr_data.pinned = 1'b1;
          end
          bst_pkg::OP_UNPIN: begin
            wr_en          = 1'b1;
            wr_data.pinned = 1'b0;
          end
          bst_pkg::OP_DIRTY: begin
            wr_en         = 1'b1;
            wr_data.dirty = 1'b1;
          end
          bst_pkg::OP_UNDIRTY: begin
            wr_en         = 1'b1;
            wr_data.dirty = 1'b0;
          end
          bst_pkg::OP_RELEASE: begin
            if (cnt_zero || seen.pinned) begin
              res_status_next = bst_pkg::STAT_IGNORED;
            end else begin
              wr_en         = 1'b1;
              wr_data.refs  = seen.refs - bst_pkg::REF_W'(1);
              wr_data.dirty = 1'b0;
              if (seen.dirty) begin
                res_wb_next  = 1'b1;
                res_wbf_next = seen.file;
                res_wbo_next = seen.offset;
              end
            end
          end
          default: begin
            res_status_next = bst_pkg::STAT_IGNORED;
          end
        endcase
      end
    end
  end

  // Capture the operation and run the scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr   <= '0;
      eval_vld  <= 1'b0;
      have_free <= 1'b0;
    end else begin
      eval_vld <= cmd.scan && (rd_addr < bst_pkg::CNT_W'(bst_pkg::NUM_SLOTS));
      if (cmd.load) begin
        rd_addr   <= '0;
        have_free <= 1'b0;
      end else if (cmd.scan) begin
        if (rd_addr < bst_pkg::CNT_W'(bst_pkg::NUM_SLOTS)) begin
          rd_addr <= rd_addr + bst_pkg::CNT_W'(1);
        end
        if (eval_vld && !have_free && cnt_zero) begin
          have_free <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    eval_idx <= rd_addr[bst_pkg::SLOT_W-1:0];
    if (cmd.load) begin
      op_r   <= in_op;
      fid_r  <= in_fid;
      off_r  <= in_off;
      slot_r <= in_slot;
    end
    if (scan_eval && !have_free && cnt_zero) begin
      free_slot <= eval_idx;
    end
    if (done) begin
      res_slot   <= res_slot_next;
      res_status <= res_status_next;
      res_hit    <= res_hit_next;
      res_nload  <= res_nload_next;
      res_wb     <= res_wb_next;
      res_wbf    <= res_wbf_next;
      res_wbo    <= res_wbo_next;
    end
    if (cmd.out_load) begin
      m_tdata <= bst_pkg::OUT_W'({res_wbo, res_wbf, res_wb, res_nload, res_hit,
                                  res_status, res_slot});
    end
  end

  // Table memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_sel];
  end

  // Slots never written read as cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      init_bits <= '0;
      rd_init   <= 1'b0;
    end else begin
      if (wr_en) begin
        init_bits[wr_addr] <= 1'b1;
      end
      rd_init <= init_bits[rd_sel];
    end
  end

endmodule

FILE: sv/buffer_slot_table_unit.sv
`timescale 1ns / 1ps

// Buffer pool slot table: tags, reference counts and flags for 64 slots.
// Slave stream s_*: one beat per request (get, mark loaded, pin, unpin,
// dirty, undirty, release, flush by file). Master stream m_*: exactly one
// result beat per request, in request order.
// Get and flush walk the slot memory one slot per cycle through a registered
// read: a get ends early on a hit, and a flush ends early at a matching slot
// that is still referenced. Single-slot operations read the slot, update it
// and hand the result off.
// One request is in work at a time. A finished result sits in the output
// register; the next request is accepted while it waits. When the receiver
// stalls, the following result is held internally and the unit stops taking
// requests until the output register frees.
// Reset clears all control state and marks every slot as never written,
// so the table reads as all zero at once; no clearing pass is needed.
module buffer_slot_table_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // op[2:0], file_id[18:3], block_offset[42:19], slot[48:43], zero pad
  input  logic [bst_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // result_slot[5:0], status[7:6], hit[8], needs_load[9], write_back[10],
  // wb_file_id[26:11], wb_offset[50:27], zero pad
  output logic [bst_pkg::OUT_W-1:0]  m_tdata
);

  bst_pkg::cmd_t  cmd;
  bst_pkg::stat_t stat;

  bst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bst_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule
